[rtl/core/atp_pkg.sv]
// Package for the abbreviation table stream parser.
// Holds the value width, field phase and result kind codes, and the queued result record.
// No dependencies.
package atp_pkg;

    // Width of a decoded ULEB128 value; higher bits are dropped and flagged
    localparam int VALUE_BITS = 64;
    localparam int OUT_BITS   = 64;
    localparam int EXT_W      = VALUE_BITS + 7;
    localparam int SHIFT_W    = $clog2(VALUE_BITS + 1);

    // Result queue between parser and output stage
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Byte payload
    localparam logic [6:0] LOW_MASK  = 7'h7f;
    localparam int         CONT_BIT  = 7;

    typedef enum logic [2:0] {
        PH_CODE  = 3'd0,
        PH_TAG   = 3'd1,
        PH_CHILD = 3'd2,
        PH_ATTR  = 3'd3,
        PH_FORM  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        K_HEADER    = 2'd0,
        K_SPEC      = 2'd1,
        K_END       = 2'd2,
        K_TABLE_END = 2'd3
    } kind_t;

    // Raw result as the parser classifies it; the output stage formats it
    typedef struct packed {
        kind_t                 kind;
        logic [VALUE_BITS-1:0] code;
        logic [VALUE_BITS-1:0] tag;
        logic                  child;
        logic [VALUE_BITS-1:0] attr;
        logic [VALUE_BITS-1:0] form;
        logic                  ovf;
    } res_rec_t;

endpackage

[rtl/core/atp_ifs.sv]
// Channel interfaces of the abbreviation table stream parser.
// Input byte channel and output result channel, valid/ready handshake.
// No dependencies.
interface atp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_table;

    modport source (output valid, output data_byte, output start_of_table, input ready);
    modport sink   (input valid, input data_byte, input start_of_table, output ready);
endinterface

interface atp_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] entry_code;
    logic [63:0] entry_tag;
    logic        children_flag;
    logic [63:0] attribute_name;
    logic [63:0] attribute_form;
    logic        value_overflow;

    modport source (
        output valid, output kind, output entry_code, output entry_tag,
        output children_flag, output attribute_name, output attribute_form,
        output value_overflow, input ready
    );
    modport sink (
        input valid, input kind, input entry_code, input entry_tag,
        input children_flag, input attribute_name, input attribute_form,
        input value_overflow, output ready
    );
endinterface

[rtl/core/atp_front.sv]
// Front part: accepts section bytes, decodes ULEB128 and tracks the field phase.
// Pushes one classified result record into the queue per result-producing byte.
// Depends on atp_pkg and atp_ifs.
module atp_front (
    input  logic               clk,
    input  logic               rst_n,
    atp_byte_if.sink           bytes,
    input  logic               q_ready,
    output logic               push,
    output atp_pkg::res_rec_t  rec
);

    atp_pkg::phase_t                    phase_reg, phase_next, cur_phase;
    logic [atp_pkg::VALUE_BITS-1:0]     acc_reg, acc_next, cur_acc, acc_take;
    logic [atp_pkg::SHIFT_W-1:0]        shift_reg, shift_next, cur_shift, shift_take;
    logic [atp_pkg::SHIFT_W:0]          shift_sum;
    logic [atp_pkg::VALUE_BITS-1:0]     code_reg, code_next;
    logic [atp_pkg::VALUE_BITS-1:0]     tag_reg, tag_next;
    logic [atp_pkg::VALUE_BITS-1:0]     attr_reg, attr_next;
    logic                               ovf_reg, ovf_next, cur_ovf, ovf_take;
    logic                               done_reg, done_next, cur_done;
    logic [atp_pkg::EXT_W-1:0]          placed;
    logic [6:0]                         low;
    logic                               fire, start, last, in_range, spill, value_zero;

    assign bytes.ready = q_ready;
    assign fire        = bytes.valid & q_ready;
    assign start       = bytes.start_of_table;

    // Apply a restart before the byte is looked at
    always_comb
    begin
        cur_phase = start ? atp_pkg::PH_CODE : phase_reg;
        cur_acc   = start ? '0 : acc_reg;
        cur_shift = start ? '0 : shift_reg;
        cur_ovf   = start ? 1'b0 : ovf_reg;
        cur_done  = start ? 1'b0 : done_reg;
    end

    // Fold one ULEB128 byte into the accumulator
    always_comb
    begin
        low        = bytes.data_byte[6:0] & atp_pkg::LOW_MASK;
        last       = ~bytes.data_byte[atp_pkg::CONT_BIT];
        in_range   = cur_shift < atp_pkg::SHIFT_W'(atp_pkg::VALUE_BITS);
        placed     = atp_pkg::EXT_W'(low) << cur_shift;
        shift_sum  = (atp_pkg::SHIFT_W + 1)'(cur_shift) + (atp_pkg::SHIFT_W + 1)'(7);
        if (in_range)
        begin
            acc_take = cur_acc | placed[atp_pkg::VALUE_BITS-1:0];
            spill    = |placed[atp_pkg::EXT_W-1:atp_pkg::VALUE_BITS];
            if (shift_sum > (atp_pkg::SHIFT_W + 1)'(atp_pkg::VALUE_BITS))
                shift_take = atp_pkg::SHIFT_W'(atp_pkg::VALUE_BITS);
            else
                shift_take = shift_sum[atp_pkg::SHIFT_W-1:0];
        end
        else
        begin
            acc_take   = cur_acc;
            spill      = |low;
            shift_take = cur_shift;
        end
        ovf_take   = cur_ovf | spill;
        value_zero = (acc_take == '0);
    end

    // Next field phase
    always_comb
    begin
        phase_next = fire ? cur_phase : phase_reg;
        if (fire && !cur_done)
        begin
            unique case (cur_phase)
                atp_pkg::PH_CODE:
                    if (last && !value_zero)
                        phase_next = atp_pkg::PH_TAG;
                atp_pkg::PH_TAG:
                    if (last)
                        phase_next = atp_pkg::PH_CHILD;
                atp_pkg::PH_CHILD:
                    phase_next = atp_pkg::PH_ATTR;
                atp_pkg::PH_ATTR:
                    if (last)
                        phase_next = atp_pkg::PH_FORM;
                atp_pkg::PH_FORM:
                    if (last)
                        phase_next = (attr_reg != '0) ? atp_pkg::PH_ATTR : atp_pkg::PH_CODE;
                default:
                    phase_next = atp_pkg::PH_CODE;
            endcase
        end
    end

    // Datapath updates and result push
    always_comb
    begin
        acc_next   = acc_reg;
        shift_next = shift_reg;
        ovf_next   = ovf_reg;
        done_next  = done_reg;
        code_next  = code_reg;
        tag_next   = tag_reg;
        attr_next  = attr_reg;
        push       = 1'b0;
        rec.kind   = atp_pkg::K_HEADER;
        rec.code   = code_reg;
        rec.tag    = tag_reg;
        rec.child  = |bytes.data_byte;
        rec.attr   = attr_reg;
        rec.form   = acc_take;
        rec.ovf    = cur_ovf;
        if (fire)
        begin
            acc_next   = cur_acc;
            shift_next = cur_shift;
            ovf_next   = cur_ovf;
            done_next  = cur_done;
            if (!cur_done)
            begin
                if (cur_phase == atp_pkg::PH_CHILD)
                begin
                    push     = 1'b1;
                    rec.kind = atp_pkg::K_HEADER;
                    ovf_next = 1'b0;
                end
                else
                begin
                    ovf_next = ovf_take;
                    rec.ovf  = ovf_take;
                    if (last)
                    begin
                        acc_next   = '0;
                        shift_next = '0;
                    end
                    else
                    begin
                        acc_next   = acc_take;
                        shift_next = shift_take;
                    end
                    if (last)
                    begin
                        unique case (cur_phase)
                            atp_pkg::PH_CODE:
                                if (value_zero)
                                begin
                                    push      = 1'b1;
                                    rec.kind  = atp_pkg::K_TABLE_END;
                                    done_next = 1'b1;
                                    ovf_next  = 1'b0;
                                end
                                else
                                    code_next = acc_take;
                            atp_pkg::PH_TAG:
                                tag_next = acc_take;
                            atp_pkg::PH_ATTR:
                                attr_next = acc_take;
                            atp_pkg::PH_FORM:
                            begin
                                push     = 1'b1;
                                rec.kind = (attr_reg != '0) ? atp_pkg::K_SPEC : atp_pkg::K_END;
                                ovf_next = 1'b0;
                            end
                            default:
                                acc_next = '0;
                        endcase
                    end
                end
            end
        end
    end

    // Hold parser control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= atp_pkg::PH_CODE;
            acc_reg   <= '0;
            shift_reg <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    // Hold decoded entry fields
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        tag_reg  <= tag_next;
        attr_reg <= attr_next;
    end

endmodule

[rtl/core/atp_queue.sv]
// Short result queue between the parser and the output stage.
// Two-entry FIFO of result records.
// Depends on atp_pkg.
module atp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  atp_pkg::res_rec_t  push_rec,
    output logic               push_ready,
    input  logic               pop,
    output logic               pop_valid,
    output atp_pkg::res_rec_t  pop_rec
);

    atp_pkg::res_rec_t            mem_reg [atp_pkg::QDEPTH];
    logic [atp_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [atp_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [atp_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                         do_push, do_pop;

    assign push_ready = (count_reg != atp_pkg::QCNT_W'(atp_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_rec    = mem_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & pop_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == atp_pkg::QPTR_W'(atp_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == atp_pkg::QPTR_W'(atp_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed records
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

[rtl/core/atp_back.sv]
// Back part: pops result records and formats them into the output register.
// Zeroes fields that do not belong to the result kind; values keep their full width.
// Depends on atp_pkg and atp_ifs.
module atp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  atp_pkg::res_rec_t  q_rec,
    output logic               pop,
    atp_item_if.source         items
);

    logic                          valid_reg, valid_next;
    logic [1:0]                    kind_reg, kind_next;
    logic [atp_pkg::OUT_BITS-1:0]  code_reg, code_next;
    logic [atp_pkg::OUT_BITS-1:0]  tag_reg, tag_next;
    logic                          child_reg, child_next;
    logic [atp_pkg::OUT_BITS-1:0]  attr_reg, attr_next;
    logic [atp_pkg::OUT_BITS-1:0]  form_reg, form_next;
    logic                          ovf_reg, ovf_next;
    logic                          is_spec, is_tend;

    assign pop     = q_valid & (~valid_reg | items.ready);
    assign is_spec = (q_rec.kind == atp_pkg::K_SPEC);
    assign is_tend = (q_rec.kind == atp_pkg::K_TABLE_END);

    // Format the record at the head of the queue
    always_comb
    begin
        kind_next  = 2'(q_rec.kind);
        code_next  = is_tend ? '0 : atp_pkg::OUT_BITS'(q_rec.code);
        tag_next   = is_tend ? '0 : atp_pkg::OUT_BITS'(q_rec.tag);
        child_next = (q_rec.kind == atp_pkg::K_HEADER) & q_rec.child;
        attr_next  = is_spec ? atp_pkg::OUT_BITS'(q_rec.attr) : '0;
        form_next  = is_spec ? atp_pkg::OUT_BITS'(q_rec.form) : '0;
        ovf_next   = q_rec.ovf;
        valid_next = valid_reg;
        if (pop)
            valid_next = 1'b1;
        else if (items.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load the output register on pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= kind_next;
            code_reg  <= code_next;
            tag_reg   <= tag_next;
            child_reg <= child_next;
            attr_reg  <= attr_next;
            form_reg  <= form_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign items.valid          = valid_reg;
    assign items.kind           = kind_reg;
    assign items.entry_code     = code_reg;
    assign items.entry_tag      = tag_reg;
    assign items.children_flag  = child_reg;
    assign items.attribute_name = attr_reg;
    assign items.attribute_form = form_reg;
    assign items.value_overflow = ovf_reg;

endmodule

[rtl/core/abbrev_table_stream_parser.sv]
// Channel  Dir  Payload                                          Handshake
// bytes    in   data_byte, start_of_table                        valid/ready
// items    out  kind, entry_code, entry_tag, children_flag,      valid/ready
//               attribute_name, attribute_form, value_overflow
//
// One byte is taken per cycle while the queue is not full; the parser updates its
// ULEB128 accumulator and field phase in the same cycle. The edge that takes a byte
// writes its result into the queue; the output register loads it from the queue
// when it is empty or being taken, and the result is offered from that register.
// The two-entry queue lets the parser keep taking bytes while a result waits;
// bytes stall only when the queue is full. Reset leaves the parser expecting a code.
// Top level of the abbreviation table stream parser; depends on atp_pkg, atp_ifs,
// atp_front, atp_queue and atp_back.
module abbrev_table_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    atp_byte_if.sink    bytes,
    atp_item_if.source  items
);

    logic               push, push_ready, pop, pop_valid;
    atp_pkg::res_rec_t  push_rec, pop_rec;

    atp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .q_ready (push_ready),
        .push    (push),
        .rec     (push_rec)
    );

    atp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_rec    (pop_rec)
    );

    atp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_rec   (pop_rec),
        .pop     (pop),
        .items   (items)
    );

endmodule
